// ----- rtl/aes_ctr_byte_stream_cipher_assert.svh -----
// ----------------------------------------------------------------------------
// AES-CTR byte stream cipher assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef AES_CTR_BYTE_STREAM_CIPHER_ASSERT_SVH
`define AES_CTR_BYTE_STREAM_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define ACBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("acbs assertion failed");
`define ACBS_ASSERT_IF(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("acbs assertion failed");
`else
`define ACBS_ASSERT(lbl, prop)
`define ACBS_ASSERT_IF(lbl, cond, prop)
`endif
`endif

// ----- rtl/acbs_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-CTR byte stream cipher package
// Shared types, register indexes and AES round functions.
// ----------------------------------------------------------------------------
package acbs_pkg;

  localparam int unsigned BlockBytes   = 16;
  localparam int unsigned CounterBytes = 8;

  localparam logic [2:0] CFG_KEY_MODE = 3'd0;
  localparam logic [2:0] CFG_KEY_0    = 3'd1;
  localparam logic [2:0] CFG_KEY_1    = 3'd2;
  localparam logic [2:0] CFG_KEY_2    = 3'd3;
  localparam logic [2:0] CFG_KEY_3    = 3'd4;

  localparam logic [1:0] MODE_AES128 = 2'd1;
  localparam logic [1:0] MODE_AES192 = 2'd2;
  localparam logic [1:0] MODE_AES256 = 2'd3;

  typedef enum logic {KX_IDLE, KX_RUN} kx_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    logic         done;
    logic [63:0]  tag;
    logic [127:0] block;
  } eng_res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3, all;
    a0  = w[31:24];
    a1  = w[23:16];
    a2  = w[15:8];
    a3  = w[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    mix_column = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                  a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8 * (i + 4 * c) -: 8] = SBOX[s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 32 * c -: 32] = mix_column(t[127 - 32 * c -: 32]);
      end
    end
    aes_round = t ^ rk;
  endfunction

endpackage

// ----- rtl/acbs_front.sv -----
// ----------------------------------------------------------------------------
// AES-CTR front queue
// Accepts byte transactions and holds up to two for the back end.
// ----------------------------------------------------------------------------
module acbs_front import acbs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  take,
  output logic  head_valid,
  output item_t head
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_take;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_take;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ----- rtl/acbs_keyexp.sv -----
// ----------------------------------------------------------------------------
// AES-CTR key expansion
// Expands the key registers into round keys, one word per cycle.
// ----------------------------------------------------------------------------
module acbs_keyexp import acbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart_exp,
  input  logic [1:0]         key_mode,
  input  logic [3:0][63:0]   key_words,
  input  logic [3:0]         rd_idx,
  output logic [127:0]       rd_key,
  output logic [3:0]         nr,
  output logic               ready
);

  kx_state_t    state_r, state_nxt;
  logic [5:0]   idx_r;
  logic [2:0]   kc_r;
  logic [7:0]   rcon_r;
  logic [31:0]  win_r [8];
  logic [127:0] rk_r [15];
  logic [1:0]   mode_eff;
  logic [3:0]   nk;
  logic [5:0]   last_idx;
  logic [31:0]  t_word, old_word, new_word;
  logic         running;

  always_comb begin
    mode_eff = (key_mode == 2'd0) ? MODE_AES256 : key_mode;
    unique case (mode_eff)
      MODE_AES128: nk = 4'd4;
      MODE_AES192: nk = 4'd6;
      default:     nk = 4'd8;
    endcase
    nr       = nk + 4'd6;
    last_idx = {nr, 2'b11};
    unique case (mode_eff)
      MODE_AES128: old_word = win_r[3];
      MODE_AES192: old_word = win_r[5];
      default:     old_word = win_r[7];
    endcase
    t_word = win_r[0];
    if (kc_r == 3'd0) begin
      t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_r, 24'd0};
    end else if (nk == 4'd8 && kc_r == 3'd4) begin
      t_word = sub_word(t_word);
    end
    if ({2'b00, idx_r} < {4'd0, nk}) begin
      new_word = idx_r[0] ? key_words[idx_r[2:1]][31:0] : key_words[idx_r[2:1]][63:32];
    end else begin
      new_word = old_word ^ t_word;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      KX_IDLE: if (restart_exp) state_nxt = KX_RUN;
      KX_RUN:  if (!restart_exp && idx_r == last_idx) state_nxt = KX_IDLE;
      default: state_nxt = KX_RUN;
    endcase
  end

  always_comb begin
    running = (state_r == KX_RUN);
    ready   = (state_r == KX_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KX_RUN;
      idx_r   <= 6'd0;
      kc_r    <= 3'd0;
      rcon_r  <= 8'h01;
    end else begin
      state_r <= state_nxt;
      if (restart_exp) begin
        idx_r  <= 6'd0;
        kc_r   <= 3'd0;
        rcon_r <= 8'h01;
      end else if (running) begin
        idx_r <= idx_r + 6'd1;
        kc_r  <= ({1'b0, kc_r} == nk - 4'd1) ? 3'd0 : kc_r + 3'd1;
        if ({2'b00, idx_r} >= {4'd0, nk} && kc_r == 3'd0) begin
          rcon_r <= xtime(rcon_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running && !restart_exp) begin
      win_r[0] <= new_word;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k - 1];
      end
      rk_r[idx_r[5:2]][{~idx_r[1:0], 5'd0} +: 32] <= new_word;
    end
  end

  assign rd_key = rk_r[rd_idx];

endmodule

// ----- rtl/acbs_aes.sv -----
// ----------------------------------------------------------------------------
// AES-CTR block engine
// Encrypts one counter block, one round per cycle.
// ----------------------------------------------------------------------------
module acbs_aes import acbs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         abort,
  input  logic [63:0]  tag_in,
  input  logic [3:0]   nr,
  input  logic [127:0] rk,
  output logic [3:0]   rk_idx,
  output logic         busy,
  output eng_res_t     res
);

  logic         busy_r;
  logic [3:0]   rnd_r;
  logic [127:0] st_r, st_nxt;
  logic [63:0]  tag_r;
  logic [127:0] blk;
  logic         finish;

  always_comb begin
    blk = '0;
    for (int k = 0; k < CounterBytes; k++) begin
      blk[127 - 8 * k -: 8] = tag_in[8 * k +: 8];
    end
    rk_idx = busy_r ? rnd_r : 4'd0;
    finish = busy_r && (rnd_r == nr);
    st_nxt = busy_r ? aes_round(st_r, rk, finish) : (blk ^ rk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 4'd0;
    end else if (abort) begin
      busy_r <= 1'b0;
    end else if (!busy_r && start) begin
      busy_r <= 1'b1;
      rnd_r  <= 4'd1;
    end else if (busy_r) begin
      busy_r <= !finish;
      rnd_r  <= rnd_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r || start) begin
      st_r <= st_nxt;
    end
    if (!busy_r && start) begin
      tag_r <= tag_in;
    end
  end

  assign busy       = busy_r;
  assign res.done   = finish && !abort;
  assign res.tag    = tag_r;
  assign res.block  = st_nxt;

endmodule

// ----- rtl/aes_ctr_byte_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// AES-CTR byte stream cipher
// XORs each data byte with an AES-CTR keystream byte (little-endian counter).
// ----------------------------------------------------------------------------
// Input transactions enter through push/full, results leave through empty/pop
// in the same order, one result per input byte. Configuration writes (cfg_we,
// cfg_index, cfg_wdata) go to the key mode and the four 64-bit key words;
// the user must make them only while the block is idle, and the block itself
// does not enforce this. A two-entry front queue takes bytes; the back end
// XORs the head byte with the current keystream block and places it in an
// output register. While the next keystream block is ready and the receiver
// pops, a byte passes through the front queue and the output register, and
// one byte per cycle is sustained. The block engine runs Nr rounds (10, 12 or
// 14) per keystream block and computes the next block while the current one
// is used. After reset and after each configuration write, the key schedule
// produces 44, 52 or 60 words; the first byte after that, and after a
// restart, waits for a fresh block. Reset empties both queues and sets the
// counter to zero. When the receiver does not pop, the output register holds
// and the front queue fills, then full stalls the sender.
// ----------------------------------------------------------------------------
`include "aes_ctr_byte_stream_cipher_assert.svh"
module aes_ctr_byte_stream_cipher import acbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  input  logic        in_buffer_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_result_byte,
  output logic        out_buffer_end_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [1:0]       mode_r;
  logic [3:0][63:0] key_r;
  item_t            item_in, head;
  logic             head_valid, take;
  logic [63:0]      cnt_r;
  logic [127:0]     ks_r;
  logic [4:0]       pos_r;
  logic [127:0]     pf_r;
  logic [63:0]      pf_tag_r;
  logic             pf_val_r;
  logic             out_v_r;
  logic [7:0]       out_data_r;
  logic             out_end_r;
  logic             need, blk_ok, fire, out_room;
  logic [63:0]      need_tag, want_tag;
  logic [7:0]       ks_byte;
  logic             eng_start, eng_busy, kx_ready;
  logic [3:0]       nr, rk_idx;
  logic [127:0]     rk;
  eng_res_t         eng_res;

  assign item_in = '{data_byte: in_data_byte, restart: in_restart,
                     buffer_end: in_buffer_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_AES256;
      key_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_MODE: mode_r   <= cfg_wdata[1:0];
        CFG_KEY_0:    key_r[0] <= cfg_wdata;
        CFG_KEY_1:    key_r[1] <= cfg_wdata;
        CFG_KEY_2:    key_r[2] <= cfg_wdata;
        CFG_KEY_3:    key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  acbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .item_in    (item_in),
    .full       (full),
    .take       (take),
    .head_valid (head_valid),
    .head       (head)
  );

  acbs_keyexp u_keyexp (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart_exp (cfg_we),
    .key_mode    (mode_r),
    .key_words   (key_r),
    .rd_idx      (rk_idx),
    .rd_key      (rk),
    .nr          (nr),
    .ready       (kx_ready)
  );

  always_comb begin
    need      = head.restart || pos_r[4];
    need_tag  = head.restart ? 64'd1 : cnt_r + 64'd1;
    want_tag  = (head_valid && head.restart) ? 64'd1 : cnt_r + 64'd1;
    blk_ok    = !need || (pf_val_r && pf_tag_r == need_tag);
    out_room  = !out_v_r || pop;
    fire      = head_valid && blk_ok && out_room;
    take      = fire;
    ks_byte   = need ? pf_r[127:120] : ks_r[{~pos_r[3:0], 3'b000} +: 8];
    eng_start = kx_ready && !eng_busy && !cfg_we &&
                !(pf_val_r && pf_tag_r == want_tag);
  end

  acbs_aes u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (eng_start),
    .abort  (cfg_we),
    .tag_in (want_tag),
    .nr     (nr),
    .rk     (rk),
    .rk_idx (rk_idx),
    .busy   (eng_busy),
    .res    (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 64'd0;
      pos_r    <= 5'd16;
      pf_val_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (fire) begin
        if (need) begin
          cnt_r <= need_tag;
          pos_r <= 5'd1;
        end else begin
          pos_r <= pos_r + 5'd1;
        end
      end
      if (cfg_we) begin
        pf_val_r <= 1'b0;
      end else if (eng_res.done) begin
        pf_val_r <= 1'b1;
      end else if (fire && need) begin
        pf_val_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && need) begin
      ks_r <= pf_r;
    end
    if (eng_res.done) begin
      pf_r     <= eng_res.block;
      pf_tag_r <= eng_res.tag;
    end
    if (fire) begin
      out_data_r <= head.data_byte ^ ks_byte;
      out_end_r  <= head.buffer_end;
    end
  end

  assign empty              = !out_v_r;
  assign out_result_byte    = out_data_r;
  assign out_buffer_end_out = out_end_r;

  `ACBS_ASSERT_IF(a_block_ready, fire && need, pf_val_r && pf_tag_r == need_tag)
  `ACBS_ASSERT_IF(a_start_keys, eng_start, kx_ready && !eng_busy)
  `ACBS_ASSERT_IF(a_out_hold, out_v_r && !pop, !fire)
  `ACBS_ASSERT(a_pos_range, pos_r <= 5'd16)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-CTR byte stream cipher testbench
// Drives byte transactions through the push/full side under a series of key
// settings. The scoreboard predicts each result byte from its own AES-CTR
// model with a little-endian counter. Results are checked in order as they
// are popped. Both sides stall at random, and the receiver holds off once
// for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb;
  import acbs_pkg::*;

  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [1:0] MODE_DEFAULT = 2'd0;

  localparam logic [7:0] SUB_BYTE [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef struct {
    logic [7:0] cipher_byte;
    logic       last_flag;
  } cipher_out_t;

  class keystream_scoreboard;
    logic [1:0]  key_mode;
    logic [63:0] key_words [4];
    logic [63:0] block_count;
    logic [7:0]  key_block [16];
    int unsigned next_pos;
    cipher_out_t pending_bytes [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned restarts;

    function new();
      key_mode = MODE_AES256;
      foreach (key_words[i]) key_words[i] = '0;
      block_count = '0;
      foreach (key_block[i]) key_block[i] = '0;
      next_pos = 16;
      errors = 0;
      checked = 0;
      restarts = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      if (idx == CFG_KEY_MODE) key_mode = value[1:0];
      else if (idx <= CFG_KEY_3) key_words[idx - 1] = value;
    endfunction

    function logic [7:0] key_byte(int unsigned k);
      logic [63:0] word;
      word = key_words[k / 8];
      return word[63 - 8 * (k % 8) -: 8];
    endfunction

    function void next_key_block();
      logic [7:0] w [60][4];
      logic [7:0] rk [15][16];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] tw [4];
      logic [7:0] f, rcon, a0, a1, a2, a3, all;
      int unsigned m, nk, nr;
      m = (key_mode == MODE_DEFAULT) ? 3 : key_mode;
      nk = 4 + 2 * (m - 1);
      nr = nk + 6;
      rcon = 8'h01;
      for (int i = 0; i < nk; i++)
        for (int j = 0; j < 4; j++) w[i][j] = key_byte(4 * i + j);
      for (int i = nk; i < 4 * (nr + 1); i++) begin
        for (int j = 0; j < 4; j++) tw[j] = w[i - 1][j];
        if (i % nk == 0) begin
          f = tw[0];
          tw[0] = SUB_BYTE[tw[1]] ^ rcon;
          tw[1] = SUB_BYTE[tw[2]];
          tw[2] = SUB_BYTE[tw[3]];
          tw[3] = SUB_BYTE[f];
          rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
        end else if (nk > 6 && i % nk == 4) begin
          for (int j = 0; j < 4; j++) tw[j] = SUB_BYTE[tw[j]];
        end
        for (int j = 0; j < 4; j++) w[i][j] = w[i - nk][j] ^ tw[j];
      end
      for (int r = 0; r <= nr; r++)
        for (int j = 0; j < 16; j++) rk[r][j] = w[4 * r + j / 4][j % 4];
      for (int i = 0; i < 16; i++)
        s[i] = ((i < 8) ? block_count[8 * i +: 8] : 8'h00) ^ rk[0][i];
      for (int r = 1; r <= nr; r++) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) t[i + 4 * c] = SUB_BYTE[s[i + 4 * ((c + i) % 4)]];
        if (r != nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
            t[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
            t[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
            t[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r][i];
      end
      key_block = s;
    endfunction

    function logic [7:0] gf_double(logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function void note_input(logic [7:0] data, logic restart, logic last);
      cipher_out_t e;
      if (restart) begin
        block_count = '0;
        next_pos = 16;
        restarts++;
      end
      if (next_pos >= 16) begin
        block_count = block_count + 64'd1;
        next_key_block();
        next_pos = 0;
      end
      e.cipher_byte = data ^ key_block[next_pos];
      e.last_flag = last;
      next_pos++;
      pending_bytes.push_back(e);
    endfunction

    function void check_result(logic [7:0] got_byte, logic got_last);
      cipher_out_t e;
      if (pending_bytes.size() == 0) begin
        $error("result_byte %02h arrived with no transaction outstanding", got_byte);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      checked++;
      if (got_byte !== e.cipher_byte) begin
        $error("result_byte: expected %02h, actual %02h", e.cipher_byte, got_byte);
        errors++;
      end
      if (got_last !== e.last_flag) begin
        $error("buffer_end_out: expected %0b, actual %0b", e.last_flag, got_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = '0;
  logic        in_restart = 1'b0;
  logic        in_buffer_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_result_byte;
  logic        out_buffer_end_out;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  keystream_scoreboard sb = new();
  bit          stalls_on = 1'b1;
  bit          long_hold = 1'b0;
  bit          rx_running = 1'b0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles = 0;

  aes_ctr_byte_stream_cipher dut (
    .clk, .rst_n, .push, .full, .in_data_byte, .in_restart, .in_buffer_end,
    .empty, .pop, .out_result_byte, .out_buffer_end_out,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transaction for %0d cycles.", WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    wait (rx_running);
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) sb.check_result(out_result_byte, out_buffer_end_out);
    end
  end

  task automatic send_byte(logic [7:0] data, logic restart, logic last);
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= data;
    in_restart <= restart;
    in_buffer_end <= last;
    do @(posedge clk); while (full);
    sb.note_input(data, restart, last);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key(logic [1:0] mode, logic [63:0] k0, logic [63:0] k1,
                         logic [63:0] k2, logic [63:0] k3);
    write_cfg(CFG_KEY_MODE, {62'd0, mode});
    write_cfg(CFG_KEY_0, k0);
    write_cfg(CFG_KEY_1, k1);
    write_cfg(CFG_KEY_2, k2);
    write_cfg(CFG_KEY_3, k3);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_buffers(int unsigned count, bit start_fresh);
    int unsigned left;
    int unsigned run;
    bit          fresh;
    left = count;
    fresh = start_fresh;
    while (left > 0) begin
      run = $urandom_range(1, 40);
      if (run > left) run = left;
      for (int i = 0; i < run; i++) begin
        send_byte(8'($urandom_range(0, 255)), fresh || ($urandom_range(0, 99) < 2),
                  (i == run - 1) ? 1'b1 : ($urandom_range(0, 19) == 0));
        fresh = 1'b0;
      end
      left -= run;
    end
  endtask

  initial begin
    logic [1:0] mode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_running = 1'b1;

    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b1);
    drain();

    set_key(MODE_AES128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b1);
    drain();

    set_key(MODE_AES192, '1, '1, '1, '0);
    send_byte(8'h3c, 1'b1, 1'b0);
    send_byte(8'hc3, 1'b0, 1'b1);
    drain();

    set_key(MODE_DEFAULT, '1, '0, '1, '0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    drain();

    // Writes to indexes past the last register must leave the key alone.
    write_cfg(CFG_SPARE_LO, '1);
    write_cfg(CFG_SPARE_HI, 64'h0123456789abcdef);
    cfg_we <= 1'b0;
    send_byte(8'h7e, 1'b0, 1'b0);
    send_byte(8'h81, 1'b1, 1'b1);
    send_byte(8'hff, 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      mode = 2'($urandom_range(0, 3));
      set_key(mode, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
      if (ph == 3) long_hold = 1'b1;
      if (ph == 11) stalls_on = 1'b0;
      send_buffers(95, 1'($urandom_range(0, 1)));
      drain();
    end

    $display("Checked %0d cipher bytes under %0d key settings with %0d restarts.",
             sb.checked, settings_used, sb.restarts);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
